[hw/rtl/swbm_pkg.sv]
// Shared types, constants and helper functions for the sliding window best match block.
// No dependencies; every other file refers to it by scoped names.
package swbm_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 5;
  localparam int CNT_W       = LEN_W;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int PCT_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = CNT_W + RECIP_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HI  = 2'd2;

  typedef struct packed {
    logic step;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic             full;
    logic [CNT_W-1:0] wcount;
    logic [CNT_W-1:0] best;
    logic             exact;
    logic             last;
  } window_t;

  typedef struct packed {
    logic             window_full;
    logic [CNT_W-1:0] window_matches;
    logic [CNT_W-1:0] best_matches;
    logic             exact_found;
    logic [PCT_W-1:0] match_percent;
    logic             is_last;
  } result_t;

  // Length in use: zero reads as one, large values clamp to the cell count.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] r;
    begin
      if (len == '0) begin
        r = LEN_W'(1);
      end else if (len > LEN_W'(MAX_PATTERN)) begin
        r = LEN_W'(MAX_PATTERN);
      end else begin
        r = len;
      end
      return r;
    end
  endfunction

  // ceil(100 * 2^16 / len); best * k >> 16 gives floor(best * 100 / len) exactly
  // for best up to the cell count.
  function automatic logic [RECIP_W-1:0] recip_k(input logic [LEN_W-1:0] len);
    logic [RECIP_W-1:0] k;
    begin
      case (len)
        5'd1:    k = 23'd6553600;
        5'd2:    k = 23'd3276800;
        5'd3:    k = 23'd2184534;
        5'd4:    k = 23'd1638400;
        5'd5:    k = 23'd1310720;
        5'd6:    k = 23'd1092267;
        5'd7:    k = 23'd936229;
        5'd8:    k = 23'd819200;
        5'd9:    k = 23'd728178;
        5'd10:   k = 23'd655360;
        5'd11:   k = 23'd595782;
        5'd12:   k = 23'd546134;
        5'd13:   k = 23'd504124;
        5'd14:   k = 23'd468115;
        5'd15:   k = 23'd436907;
        5'd16:   k = 23'd409600;
        default: k = '0;
      endcase
      return k;
    end
  endfunction

endpackage

[hw/rtl/swbm_cell.sv]
// One alignment cell: holds the running match count of one alignment.
// Depends on swbm_pkg.
module swbm_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  swbm_pkg::cell_ctl_t           ctl,
  input  logic [swbm_pkg::CHAR_W-1:0]   text_char,
  input  logic [swbm_pkg::CHAR_W-1:0]   pattern_char,
  input  logic [swbm_pkg::CNT_W-1:0]    count_in,
  output logic [swbm_pkg::CNT_W-1:0]    count_out
);

  logic [swbm_pkg::CNT_W-1:0] count;

  // Count plus this position's match, handed to the next cell.
  assign count_out = count + swbm_pkg::CNT_W'(text_char == pattern_char);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      count <= '0;
    end else if (ctl.step) begin
      count <= count_in;
    end
  end

endmodule

[hw/rtl/swbm_pct.sv]
// Output stage: last-beat percentage of the best count; holds the result beat.
// Depends on swbm_pkg.
module swbm_pct (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic                         win_valid,
  input  swbm_pkg::window_t            win,
  input  logic [swbm_pkg::LEN_W-1:0]   len,
  output swbm_pkg::result_t            res,
  output logic                         res_valid
);

  logic [swbm_pkg::PROD_W-1:0] prod;
  logic [swbm_pkg::PCT_W-1:0]  percent;

  assign prod = swbm_pkg::PROD_W'(win.best) * swbm_pkg::PROD_W'(swbm_pkg::recip_k(len));
  assign percent = win.last ? prod[swbm_pkg::RECIP_SHIFT +: swbm_pkg::PCT_W] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && win_valid) begin
      res.window_full    <= win.full;
      res.window_matches <= win.wcount;
      res.best_matches   <= win.best;
      res.exact_found    <= win.exact;
      res.match_percent  <= percent;
      res.is_last        <= win.last;
    end
  end

endmodule

[hw/rtl/sliding_window_best_match.sv]
// Sliding window best match: top level with the cell chain, window tracking and output.
// Depends on swbm_pkg, swbm_cell and swbm_pct.
// A beat is registered in stage 1, then in the output stage; one beat per cycle while
// the output is free, set by the cell chain, which steps all alignments as a byte is taken.
// Reset (rst, synchronous): all counts, window state and pipeline valids clear;
// pattern_length returns to 1 and both pattern words to zero. No clearing pass.
module sliding_window_best_match (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [swbm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [swbm_pkg::CFG_DATA_W-1:0]      cfg_data,
  // text input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [swbm_pkg::CHAR_W-1:0]          text_char,
  input  logic                                 end_of_text,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 window_full,
  output logic [swbm_pkg::CNT_W-1:0]           window_matches,
  output logic [swbm_pkg::CNT_W-1:0]           best_matches,
  output logic                                 exact_found,
  output logic [swbm_pkg::PCT_W-1:0]           match_percent,
  output logic                                 is_last
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; an unknown index is dropped.
  // ---------------------------------------------------------------------------
  logic [swbm_pkg::LEN_W-1:0]      pattern_length;
  logic [swbm_pkg::CFG_DATA_W-1:0] pattern_low;
  logic [swbm_pkg::CFG_DATA_W-1:0] pattern_high;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= swbm_pkg::LEN_W'(1);
      pattern_low    <= '0;
      pattern_high   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        swbm_pkg::REG_LENGTH:  pattern_length <= cfg_data[swbm_pkg::LEN_W-1:0];
        swbm_pkg::REG_PAT_LOW: pattern_low    <= cfg_data;
        swbm_pkg::REG_PAT_HI:  pattern_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [swbm_pkg::LEN_W-1:0] len;
  logic [swbm_pkg::LEN_W-1:0] len_m1;

  assign len    = swbm_pkg::eff_len(pattern_length);
  assign len_m1 = len - swbm_pkg::LEN_W'(1);

  // ---------------------------------------------------------------------------
  // Pipeline control. Stage 1 holds the window result of the last accepted byte,
  // the output stage holds the beat on offer. Both advance when the output is free.
  // ---------------------------------------------------------------------------
  logic advance;
  logic accept;
  logic win_valid;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !win_valid || advance;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (accept) begin
      win_valid <= 1'b1;
    end else if (advance) begin
      win_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain. Cell j holds the count of the alignment that has taken j bytes.
  // Each cell compares the byte with pattern byte j and hands count plus match
  // to cell j+1. Cells at or beyond the length in use hold their value.
  // ---------------------------------------------------------------------------
  logic [swbm_pkg::CHAR_W-1:0] pat_byte [swbm_pkg::MAX_PATTERN];
  logic [swbm_pkg::CNT_W-1:0]  sums     [swbm_pkg::MAX_PATTERN];

  for (genvar j = 0; j < swbm_pkg::MAX_PATTERN; j++) begin : g_cell
    swbm_pkg::cell_ctl_t        ctl;
    logic [swbm_pkg::CNT_W-1:0] count_in;

    if (j < 8) begin : g_low
      assign pat_byte[j] = pattern_low[swbm_pkg::CHAR_W*j +: swbm_pkg::CHAR_W];
    end else if (j < 16) begin : g_high
      assign pat_byte[j] = pattern_high[swbm_pkg::CHAR_W*(j-8) +: swbm_pkg::CHAR_W];
    end else begin : g_zero
      assign pat_byte[j] = '0;
    end

    // The first cell always starts a fresh alignment.
    if (j == 0) begin : g_head
      assign count_in = '0;
    end else begin : g_link
      assign count_in = sums[j-1];
    end

    // Drop everything on the last byte of a text; step only cells in use.
    assign ctl.clear = accept && end_of_text;
    assign ctl.step  = accept && (swbm_pkg::LEN_W'(j) < len);

    swbm_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .text_char    (text_char),
      .pattern_char (pat_byte[j]),
      .count_in     (count_in),
      .count_out    (sums[j])
    );
  end

  // ---------------------------------------------------------------------------
  // Window tracking. The window ending at this byte is the sum leaving cell len-1.
  // bytes_seen saturates at the length; best and exact cover the current text.
  // ---------------------------------------------------------------------------
  logic [swbm_pkg::LEN_W-1:0] bytes_seen;
  logic [swbm_pkg::CNT_W-1:0] best_so_far;
  logic                       exact_seen;

  logic [swbm_pkg::LEN_W:0]   seen_inc;
  logic                       full;
  logic [swbm_pkg::CNT_W-1:0] wcount;
  logic [swbm_pkg::CNT_W-1:0] best_next;
  logic                       exact_next;
  logic [swbm_pkg::LEN_W-1:0] bytes_seen_next;

  assign seen_inc = {1'b0, bytes_seen} + (swbm_pkg::LEN_W + 1)'(1);
  assign full     = seen_inc >= {1'b0, len};
  assign wcount   = full ? sums[len_m1[swbm_pkg::IDX_W-1:0]] : '0;

  always_comb begin
    best_next  = best_so_far;
    exact_next = exact_seen;
    if (full && (wcount > best_so_far)) begin
      best_next = wcount;
    end
    if (full && ({1'b0, wcount} == {1'b0, len})) begin
      exact_next = 1'b1;
    end
    if (seen_inc > {1'b0, len}) begin
      bytes_seen_next = len;
    end else begin
      bytes_seen_next = seen_inc[swbm_pkg::LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen  <= '0;
      best_so_far <= '0;
      exact_seen  <= 1'b0;
    end else if (accept) begin
      if (end_of_text) begin
        bytes_seen  <= '0;
        best_so_far <= '0;
        exact_seen  <= 1'b0;
      end else begin
        bytes_seen  <= bytes_seen_next;
        best_so_far <= best_next;
        exact_seen  <= exact_next;
      end
    end
  end

  // Stage 1 payload: the values this byte reports, including its own window.
  swbm_pkg::window_t win;

  always_ff @(posedge clk) begin
    if (accept) begin
      win.full   <= full;
      win.wcount <= wcount;
      win.best   <= best_next;
      win.exact  <= exact_next;
      win.last   <= end_of_text;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: percentage on the last byte, result beat held until taken.
  // ---------------------------------------------------------------------------
  swbm_pkg::result_t res;

  swbm_pct u_pct (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .win_valid (win_valid),
    .win       (win),
    .len       (len),
    .res       (res),
    .res_valid (out_valid)
  );

  assign window_full    = res.window_full;
  assign window_matches = res.window_matches;
  assign best_matches   = res.best_matches;
  assign exact_found    = res.exact_found;
  assign match_percent  = res.match_percent;
  assign is_last        = res.is_last;

endmodule
